@@ sv/reader_writer_lock_arbiter_unit_defines.svh @@
// Assertion macros for the reader/writer lock arbiter.
// Included by the modules that check their own logic; depends on nothing.
`ifndef READER_WRITER_LOCK_ARBITER_UNIT_DEFINES_SVH
`define READER_WRITER_LOCK_ARBITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge outside reset
`define RWLA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rwla assertion failed");
// Consequent that must hold in the cycle after the antecedent
`define RWLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwla assertion failed");
`else
`define RWLA_ASSERT(label, clk, rst, prop)
`define RWLA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/rwla_pkg.sv @@
// Shared types and constants of the reader/writer lock arbiter.
// Used by the controller, the datapath and the top level; depends on nothing.
package rwla_pkg;

   localparam int QUEUE_DEPTH_DEF        = 16;
   localparam int ID_WIDTH_DEF           = 8;
   localparam int READER_COUNT_WIDTH_DEF = 8;

   localparam int FUNC_WIDTH   = 2;
   localparam int STATUS_WIDTH = 4;

   // Request codes
   localparam logic [FUNC_WIDTH-1:0] FUNC_ACQ_READ  = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ACQ_WRITE = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_RELEASE   = 2'd2;

   // Result codes
   localparam logic [STATUS_WIDTH-1:0] ST_READ_GRANT      = 4'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_WRITE_GRANT     = 4'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_READ_QUEUED     = 4'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_WRITE_QUEUED    = 4'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_RELEASED        = 4'd4;
   localparam logic [STATUS_WIDTH-1:0] ST_QUEUE_FULL      = 4'd5;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_RELEASE     = 4'd6;
   localparam logic [STATUS_WIDTH-1:0] ST_ALREADY_WRITER  = 4'd7;
   localparam logic [STATUS_WIDTH-1:0] ST_READER_OVERFLOW = 4'd8;

   // Datapath operations issued by the controller
   typedef enum logic [1:0] {
      OP_NONE,
      OP_EVAL,
      OP_WGRANT,
      OP_RGRANT
   } op_type;

   typedef struct packed {
      logic   load_req;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic func_none;
      logic out_free;
      logic wake_w;
      logic wake_r;
      logic rd_last;
   } sts_type;

endpackage

@@ sv/rwla_fifo.sv @@
// Queue of waiting requester ids with a registered head read.
// Stand-alone; takes the assertion macros from the defines header.
`include "reader_writer_lock_arbiter_unit_defines.svh"
module rwla_fifo #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [CW-1:0]    count,
   output logic             full,
   output logic [WIDTH-1:0] head_data
);

   localparam int SW = CW + 1;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [HW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] rd_ff;
   logic [SW-1:0]    tail_sum;
   logic [HW-1:0]    tail;

   // Locate the write slot behind the last waiting entry
   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(DEPTH)) begin
         tail = HW'(tail_sum - SW'(DEPTH));
      end else begin
         tail = HW'(tail_sum);
      end
   end

   // Advance head and count
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == HW'(DEPTH - 1)) ? '0 : head_ff + HW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Write on push; prefetch the entry at the next head
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= push_data;
      end
      rd_ff <= mem[head_in];
   end

   assign count     = count_ff;
   assign full      = (count_ff == CW'(DEPTH));
   assign head_data = rd_ff;

   `RWLA_ASSERT(a_no_push_full, clock, reset, !(push && full))
   `RWLA_ASSERT(a_no_pop_empty, clock, reset, !(pop && count_ff == '0))
   `RWLA_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH))
   `RWLA_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ sv/rwla_datapath.sv @@
// Lock state, wait queues, request latch and result register of the arbiter.
// Depends on rwla_pkg and rwla_fifo; driven by commands from rwla_ctrl.
module rwla_datapath #(
   parameter int QUEUE_DEPTH        = rwla_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH           = rwla_pkg::ID_WIDTH_DEF,
   parameter int READER_COUNT_WIDTH = rwla_pkg::READER_COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rwla_pkg::cmd_type                 cmd,
   output rwla_pkg::sts_type                 sts,
   input  logic [rwla_pkg::FUNC_WIDTH-1:0]   req_func,
   input  logic [ID_WIDTH-1:0]               req_requester_id,
   input  logic                              csr_valid,
   input  logic                              csr_write_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rwla_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [ID_WIDTH-1:0]               rsp_who,
   output logic                              rsp_last
);

   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int RCW = READER_COUNT_WIDTH;

   logic                              wp_ff;
   logic [RCW-1:0]                    rc_ff, rc_in;
   logic                              held_ff, held_in;
   logic [ID_WIDTH-1:0]               wid_ff, wid_in;
   logic [rwla_pkg::FUNC_WIDTH-1:0]   func_ff;
   logic [ID_WIDTH-1:0]               id_ff;
   logic                              rsp_valid_ff;
   logic [rwla_pkg::STATUS_WIDTH-1:0] rsp_status_ff;
   logic [ID_WIDTH-1:0]               rsp_who_ff;
   logic                              rsp_last_ff;

   logic                              push_r, push_w, pop_r, pop_w;
   logic [CW-1:0]                     r_count, w_count;
   logic                              r_full, w_full;
   logic [ID_WIDTH-1:0]               r_head, w_head;

   logic                              load_out;
   logic [rwla_pkg::STATUS_WIDTH-1:0] st_sel;
   logic [ID_WIDTH-1:0]               who_sel;
   logic                              last_sel;

   logic wmatch, rc_max, rd_wait, wake, wake_w, wake_r;

   rwla_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH)) u_read_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push_r),
      .push_data (id_ff),
      .pop       (pop_r),
      .count     (r_count),
      .full      (r_full),
      .head_data (r_head)
   );

   rwla_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH)) u_write_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push_w),
      .push_data (id_ff),
      .pop       (pop_w),
      .count     (w_count),
      .full      (w_full),
      .head_data (w_head)
   );

   // Decode the latched request against the lock state
   assign wmatch  = held_ff && (wid_ff == id_ff);
   assign rc_max  = &rc_ff;
   assign rd_wait = (rc_ff == '0) ? held_ff : (wp_ff && (w_count != '0));
   assign wake    = (func_ff == rwla_pkg::FUNC_RELEASE) && (wmatch || rc_ff == RCW'(1));
   assign wake_w  = wake && (w_count != '0) && (wp_ff || r_count == '0);
   assign wake_r  = wake && (r_count != '0) && (!wp_ff || w_count == '0);

   // Work out the state update and the result of the current operation
   always_comb begin
      rc_in    = rc_ff;
      held_in  = held_ff;
      wid_in   = wid_ff;
      push_r   = 1'b0;
      push_w   = 1'b0;
      pop_r    = 1'b0;
      pop_w    = 1'b0;
      load_out = 1'b0;
      st_sel   = rwla_pkg::ST_READ_GRANT;
      who_sel  = id_ff;
      last_sel = 1'b1;
      case (cmd.op)
         rwla_pkg::OP_EVAL: begin
            load_out = 1'b1;
            last_sel = !(wake_w || wake_r);
            case (func_ff)
               rwla_pkg::FUNC_ACQ_READ: begin
                  if (rd_wait) begin
                     if (r_full) begin
                        st_sel = rwla_pkg::ST_QUEUE_FULL;
                     end else begin
                        st_sel = rwla_pkg::ST_READ_QUEUED;
                        push_r = 1'b1;
                     end
                  end else if (rc_max) begin
                     st_sel = rwla_pkg::ST_READER_OVERFLOW;
                  end else begin
                     st_sel = rwla_pkg::ST_READ_GRANT;
                     rc_in  = rc_ff + RCW'(1);
                  end
               end
               rwla_pkg::FUNC_ACQ_WRITE: begin
                  if (wmatch) begin
                     st_sel = rwla_pkg::ST_ALREADY_WRITER;
                  end else if (held_ff || rc_ff != '0) begin
                     if (w_full) begin
                        st_sel = rwla_pkg::ST_QUEUE_FULL;
                     end else begin
                        st_sel = rwla_pkg::ST_WRITE_QUEUED;
                        push_w = 1'b1;
                     end
                  end else begin
                     st_sel  = rwla_pkg::ST_WRITE_GRANT;
                     held_in = 1'b1;
                     wid_in  = id_ff;
                  end
               end
               rwla_pkg::FUNC_RELEASE: begin
                  if (wmatch) begin
                     st_sel  = rwla_pkg::ST_RELEASED;
                     held_in = 1'b0;
                     wid_in  = '0;
                  end else if (rc_ff == '0) begin
                     st_sel = rwla_pkg::ST_BAD_RELEASE;
                  end else begin
                     st_sel = rwla_pkg::ST_RELEASED;
                     rc_in  = rc_ff - RCW'(1);
                  end
               end
               default: begin
                  load_out = 1'b0;
               end
            endcase
         end
         rwla_pkg::OP_WGRANT: begin
            load_out = 1'b1;
            pop_w    = 1'b1;
            held_in  = 1'b1;
            wid_in   = w_head;
            st_sel   = rwla_pkg::ST_WRITE_GRANT;
            who_sel  = w_head;
         end
         rwla_pkg::OP_RGRANT: begin
            load_out = 1'b1;
            pop_r    = 1'b1;
            who_sel  = r_head;
            last_sel = (r_count == CW'(1));
            if (rc_max) begin
               st_sel = rwla_pkg::ST_READER_OVERFLOW;
            end else begin
               st_sel = rwla_pkg::ST_READ_GRANT;
               rc_in  = rc_ff + RCW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Hold lock state and priority mode
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rc_ff   <= '0;
         held_ff <= 1'b0;
         wid_ff  <= '0;
      end else begin
         if (csr_valid) begin
            wp_ff <= csr_write_priority;
         end
         rc_ff   <= rc_in;
         held_ff <= held_in;
         wid_ff  <= wid_in;
      end
   end

   // Latch the accepted request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         id_ff   <= req_requester_id;
      end
   end

   // Result register: load a beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff <= st_sel;
         rsp_who_ff    <= who_sel;
         rsp_last_ff   <= last_sel;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_who    = rsp_who_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      sts.func_none = (func_ff != rwla_pkg::FUNC_ACQ_READ) &&
                      (func_ff != rwla_pkg::FUNC_ACQ_WRITE) &&
                      (func_ff != rwla_pkg::FUNC_RELEASE);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.wake_w    = wake_w;
      sts.wake_r    = wake_r;
      sts.rd_last   = (r_count == CW'(1));
   end

endmodule

@@ sv/rwla_ctrl.sv @@
// Sequencer of the arbiter: accept, evaluate, then hand-off or reader drain.
// Depends on rwla_pkg; commands the datapath through cmd_type.
module rwla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwla_pkg::sts_type sts,
   output rwla_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WGRANT,
      S_RDRAIN
   } state_type;

   state_type state_ff, state_in;

   // Choose the next step and the datapath command
   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.op       = rwla_pkg::OP_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.func_none) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.op = rwla_pkg::OP_EVAL;
               if (sts.wake_w) begin
                  state_in = S_WGRANT;
               end else if (sts.wake_r) begin
                  state_in = S_RDRAIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WGRANT: begin
            if (sts.out_free) begin
               cmd.op   = rwla_pkg::OP_WGRANT;
               state_in = S_IDLE;
            end
         end
         S_RDRAIN: begin
            if (sts.out_free) begin
               cmd.op = rwla_pkg::OP_RGRANT;
               if (sts.rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/reader_writer_lock_arbiter_unit.sv @@
// Reader/writer lock arbiter with selectable reader or writer priority.
// Channels: req_ (func, requester_id) in, rsp_ (status, who, last) out,
// csr_ writes the write_priority bit and is always ready.
// A request beat is taken only while the sequencer is idle. Then, in the
// evaluate state, its own result is loaded into the output register once
// the register is free: a request passes an accept step and an evaluate step.
// A release that wakes a queued writer adds a hand-off step; one that wakes
// queued readers then drains the reader queue, one entry a cycle while the
// receiver keeps up. rsp_last marks the final result beat of each request;
// an unused func code gives no result. A stalled receiver holds the output
// register, and the sequencer waits with it, so no result is lost. The wait
// queues read their head through a registered port that prefetches the next
// entry while draining.
// Reset is synchronous: the lock is free, both queues empty, reader priority
// selected; queue entries need no clearing.
// Write csr_ only while no request is in progress.
module reader_writer_lock_arbiter_unit #(
   parameter int QUEUE_DEPTH        = rwla_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH           = rwla_pkg::ID_WIDTH_DEF,
   parameter int READER_COUNT_WIDTH = rwla_pkg::READER_COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rwla_pkg::FUNC_WIDTH-1:0]   req_func,
   input  logic [ID_WIDTH-1:0]               req_requester_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rwla_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [ID_WIDTH-1:0]               rsp_who,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_write_priority
);

   rwla_pkg::cmd_type cmd;
   rwla_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   rwla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rwla_datapath #(
      .QUEUE_DEPTH        (QUEUE_DEPTH),
      .ID_WIDTH           (ID_WIDTH),
      .READER_COUNT_WIDTH (READER_COUNT_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_requester_id   (req_requester_id),
      .csr_valid          (csr_valid),
      .csr_write_priority (csr_write_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_who            (rsp_who),
      .rsp_last           (rsp_last)
   );

endmodule
